[rtl/core/mavg_pkg.sv]
`timescale 1ns / 1ps

package mavg_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 24;
    localparam int FRAC_W   = 8;

    // Item kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Classified item as it travels through the queue
    typedef struct packed {
        logic                       is_clear;
        logic signed [SAMPLE_W-1:0] sample;
    } item_cmd_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_UPDATE
    } back_state_t;

    // Serial divider
    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_DONE
    } div_state_t;

endpackage

[rtl/core/mavg_front.sv]
`timescale 1ns / 1ps

module mavg_front
    import mavg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       q_valid,
    output item_cmd_t                  q_cmd,
    input  logic                       q_pop
);

    item_cmd_t              slot_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    item_cmd_t              cmd_in;
    logic                   push;
    logic                   pop;

    // Classify the incoming item
    always_comb
    begin
        cmd_in.is_clear = (kind == KIND_CLEAR);
        cmd_in.sample   = sample;
    end

    assign in_ready = (cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_pop;
    assign q_cmd    = slot_mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[rtl/core/mavg_div.sv]
`timescale 1ns / 1ps

module mavg_div
    import mavg_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int CNT_W = 5
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] sum,
    input  logic [CNT_W-1:0]        count,
    output logic                    idle,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [AVG_W-1:0] average
);

    localparam int DW     = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(DW);

    div_state_t          state_reg, state_next;
    logic [DW-1:0]       dq_reg, dq_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    dvs_reg, dvs_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                neg_reg, neg_next;
    logic                res_valid_reg, res_valid_next;
    logic [AVG_W-1:0]    res_reg, res_next;
    logic [SUM_W-1:0]    sum_mag;
    logic [CNT_W:0]      rem_shift;
    logic [CNT_W:0]      rem_sub;
    logic                q_bit;
    logic                last_step;
    logic                res_load;
    logic [AVG_W-1:0]    quo;

    // Magnitude of the dividend; the most negative sum still fits unsigned
    assign sum_mag   = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

    // One restoring step per cycle
    assign rem_shift = {rem_reg, dq_reg[DW-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign q_bit     = (rem_shift >= {1'b0, dvs_reg});
    assign last_step = (step_reg == STEP_W'(DW - 1));

    assign quo       = dq_reg[AVG_W-1:0];
    assign res_load  = (state_reg == D_DONE) && (!res_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (last_step)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                if (res_load)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        idle           = 1'b0;
        if (res_valid_reg && out_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            D_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    dq_next   = {sum_mag, {FRAC_W{1'b0}}};
                    rem_next  = '0;
                    dvs_next  = count;
                    step_next = '0;
                    neg_next  = sum[SUM_W-1];
                end
            end
            D_RUN:
            begin
                dq_next   = {dq_reg[DW-2:0], q_bit};
                rem_next  = q_bit ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                step_next = step_reg + 1'b1;
            end
            D_DONE:
            begin
                if (res_load)
                begin
                    res_next       = neg_reg ? (~quo + 1'b1) : quo;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= D_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign average   = res_reg;

    // Checks
    a_no_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (start && idle) |-> (count != '0))
        else $error("divider started with zero count");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && idle) |=> (state_reg == D_RUN))
        else $error("divider did not start");

    a_done_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_DONE && res_valid_reg && !out_ready) |=> res_valid_reg)
        else $error("pending result dropped");

endmodule

[rtl/core/mavg_back.sv]
`timescale 1ns / 1ps

module mavg_back
    import mavg_pkg::*;
#(
    parameter int WINDOW = 16,
    parameter int SUM_W  = 20,
    parameter int CNT_W  = 5,
    parameter int SLOT_W = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  item_cmd_t               q_cmd,
    output logic                    q_pop,
    input  logic                    div_idle,
    output logic                    div_start,
    output logic signed [SUM_W-1:0] div_sum,
    output logic [CNT_W-1:0]        div_count
);

    back_state_t                state_reg, state_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic signed [SAMPLE_W-1:0] cur_reg;
    logic signed [SAMPLE_W-1:0] ring_rd_reg;
    logic signed [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic                       take;
    logic                       take_sample;
    logic                       ring_wr;
    logic                       full;
    logic signed [SUM_W-1:0]    old_ext;
    logic signed [SUM_W-1:0]    cur_ext;
    logic signed [SUM_W-1:0]    sum_upd;
    logic [CNT_W-1:0]           count_upd;

    assign full        = (count_reg == CNT_W'(WINDOW));
    assign take        = q_valid && q_pop;
    assign take_sample = take && !q_cmd.is_clear;

    // Oldest sample drops out only once the window is full
    assign old_ext   = full ? SUM_W'(ring_rd_reg) : '0;
    assign cur_ext   = SUM_W'(cur_reg);
    assign sum_upd   = sum_reg - old_ext + cur_ext;
    assign count_upd = full ? count_reg : count_reg + 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (take_sample)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_UPDATE;
            end
            B_UPDATE:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Outputs and filter state update
    always_comb
    begin
        q_pop      = 1'b0;
        div_start  = 1'b0;
        ring_wr    = 1'b0;
        sum_next   = sum_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        case (state_reg)
            B_IDLE:
            begin
                // a clear needs no divider, a sample waits for it
                q_pop = q_cmd.is_clear || div_idle;
                if (take && q_cmd.is_clear)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    slot_next  = '0;
                end
            end
            B_READ:
            begin
                q_pop = 1'b0;
            end
            B_UPDATE:
            begin
                div_start  = 1'b1;
                ring_wr    = 1'b1;
                sum_next   = sum_upd;
                count_next = count_upd;
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign div_sum   = sum_upd;
    assign div_count = count_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            sum_reg   <= '0;
            count_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
        end
    end

    // Hold the sample being processed
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            cur_reg <= q_cmd.sample;
        end
    end

    // Sample ring: registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            ring_rd_reg <= ring_mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[slot_reg] <= cur_reg;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot beyond window");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> div_idle)
        else $error("divider started while busy");

    a_read_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |=> (state_reg == B_UPDATE))
        else $error("update step skipped");

endmodule

[rtl/core/moving_average_filter.sv]
`timescale 1ns / 1ps

// Boxcar moving average over the last WINDOW signed 16-bit samples. A sample
// item (kind 0) produces one result: the running sum times 256 divided by the
// number of samples held (up to WINDOW), truncated toward zero, as a signed
// value with 8 fraction bits; until the window fills this averages the samples
// seen so far. A clear item (kind 1) zeroes sum, fill count and write slot and
// produces no result. A two-entry queue decouples input acceptance from the
// filter core, and the result sits in an output register. In the core a sample
// is dequeued, its ring entry is read, sum and fill count are updated, the
// restoring divider (SUM_W = 16 + clog2(WINDOW)) yields one quotient bit per
// cycle and the result is loaded into the output register. A new sample is
// dequeued only once the divider is idle; a clear does not wait for it.

module moving_average_filter
    import mavg_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [AVG_W-1:0]    average
);

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic                    q_valid;
    item_cmd_t               q_cmd;
    logic                    q_pop;
    logic                    div_idle;
    logic                    div_start;
    logic signed [SUM_W-1:0] div_sum;
    logic [CNT_W-1:0]        div_count;

    // Front: accept and classify, queue commands
    mavg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sample   (sample),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    // Back: ring, running sum and fill count
    mavg_back #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W),
        .CNT_W  (CNT_W),
        .SLOT_W (SLOT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .div_idle  (div_idle),
        .div_start (div_start),
        .div_sum   (div_sum),
        .div_count (div_count)
    );

    // Serial divider with output register
    mavg_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .sum       (div_sum),
        .count     (div_count),
        .idle      (div_idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .average   (average)
    );

endmodule
